// ----- hdl/chl_pkg.sv -----
// Shared types, constants and a helper function for the C syntax highlight lexer.
// Used by the queues, the back end and the top level; depends on nothing else.
`default_nettype none
package chl_pkg;

   localparam int WIN_DEPTH = 9;
   localparam int KW_COUNT  = 23;
   localparam int QUEUE_DEPTH = 4;

   typedef logic [3:0] win_cnt_type;
   typedef logic [2:0] hl_class_type;

   localparam hl_class_type CLS_NORMAL  = 3'd0;
   localparam hl_class_type CLS_COMMENT = 3'd1;
   localparam hl_class_type CLS_BLOCK   = 3'd2;
   localparam hl_class_type CLS_KEYWORD = 3'd3;
   localparam hl_class_type CLS_TYPE    = 3'd4;
   localparam hl_class_type CLS_STRING  = 3'd5;
   localparam hl_class_type CLS_NUMBER  = 3'd6;

   localparam logic [1:0] CSR_SYNTAX_EN  = 2'd0;
   localparam logic [1:0] CSR_STRINGS_EN = 2'd1;
   localparam logic [1:0] CSR_NUMBERS_EN = 2'd2;

   typedef struct packed {
      logic [7:0] text_char;
      logic       row_end;
   } item_type;

   typedef struct packed {
      hl_class_type hl_class;
      logic         row_last;
   } result_type;

   // Keyword text is right-justified: the last character sits in bits [7:0].
   localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
      64'("switch"), 64'("if"), 64'("while"), 64'("for"), 64'("break"),
      64'("continue"), 64'("return"), 64'("else"), 64'("struct"), 64'("union"),
      64'("typedef"), 64'("static"), 64'("enum"), 64'("class"), 64'("case"),
      64'("int"), 64'("long"), 64'("double"), 64'("float"), 64'("char"),
      64'("unsigned"), 64'("signed"), 64'("void")
   };
   localparam logic [3:0] KW_LEN [KW_COUNT] = '{
      4'd6, 4'd2, 4'd5, 4'd3, 4'd5, 4'd8, 4'd6, 4'd4, 4'd6, 4'd5, 4'd7, 4'd6,
      4'd4, 4'd5, 4'd4, 4'd3, 4'd4, 4'd6, 4'd5, 4'd4, 4'd8, 4'd6, 4'd4
   };
   localparam logic KW_IS_TYPE [KW_COUNT] = '{
      1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
      1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1
   };

   function automatic logic is_sep(input logic [7:0] c);
      logic r;
      r = (c == 8'd0) || (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
      unique case (c)
         ",", ".", "(", ")", "+", "-", "/", "*", "=", "~", "%", "<", ">", "[", "]",
         ";": r = 1'b1;
         default: ;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

// ----- hdl/chl_front.sv -----
// Input queue of the lexer: holds accepted items until the back end takes them.
// Depends on chl_pkg.
`default_nettype none
module chl_front (
   input  wire               clock,
   input  wire               reset,
   input  wire               push,
   output logic              full,
   input  chl_pkg::item_type push_item,
   input  wire               pop,
   output logic              empty,
   output chl_pkg::item_type pop_item
);
   chl_pkg::item_type mem_ff [chl_pkg::QUEUE_DEPTH];
   logic [1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [2:0] cnt_ff, cnt_in;
   logic       do_push, do_pop;

   assign full     = (cnt_ff == 3'(chl_pkg::QUEUE_DEPTH));
   assign empty    = (cnt_ff == 3'd0);
   assign pop_item = mem_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + 2'(do_push);
      rd_ptr_in = rd_ptr_ff + 2'(do_pop);
      cnt_in    = cnt_ff + 3'(do_push) - 3'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end
endmodule
`default_nettype wire

// ----- hdl/chl_outq.sv -----
// Result queue of the lexer: buffers classified results until the user pops them.
// Depends on chl_pkg.
`default_nettype none
module chl_outq (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 push,
   output logic                full,
   input  chl_pkg::result_type push_res,
   input  wire                 pop,
   output logic                empty,
   output chl_pkg::result_type pop_res
);
   chl_pkg::result_type mem_ff [chl_pkg::QUEUE_DEPTH];
   logic [1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [2:0] cnt_ff, cnt_in;
   logic       do_push, do_pop;

   assign full    = (cnt_ff == 3'(chl_pkg::QUEUE_DEPTH));
   assign empty   = (cnt_ff == 3'd0);
   assign pop_res = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + 2'(do_push);
      rd_ptr_in = rd_ptr_ff + 2'(do_pop);
      cnt_in    = cnt_ff + 3'(do_push) - 3'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_res;
      end
   end
endmodule
`default_nettype wire

// ----- hdl/chl_lexer.sv -----
// Back end of the lexer: lookahead window, classification step and result emission.
// Depends on chl_pkg.
`default_nettype none
module chl_lexer (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 syntax_en,
   input  wire                 strings_en,
   input  wire                 numbers_en,
   input  wire                 in_empty,
   input  chl_pkg::item_type   in_item,
   output logic                in_pop,
   input  wire                 out_full,
   output logic                out_push,
   output chl_pkg::result_type out_res
);
   logic [7:0] win_ff [chl_pkg::WIN_DEPTH];
   logic [7:0] win_in [chl_pkg::WIN_DEPTH];
   chl_pkg::win_cnt_type cnt_ff, cnt_in;
   logic       busy_ff, busy_in, flush_ff, flush_in;
   logic [3:0] left_ff, left_in;
   chl_pkg::hl_class_type ecls_ff, ecls_in, prev_ff, prev_in;
   logic       elast_ff, elast_in;
   logic       inbc_ff, inbc_in, as_ff, as_in;
   logic [7:0] oq_ff, oq_in;

   logic       need_decide;
   logic [7:0] c, p1;
   chl_pkg::hl_class_type d_cls;
   logic [3:0] d_len;
   logic       d_keep_prev;
   logic       kw_hit, kw_ok, fits;
   chl_pkg::hl_class_type kw_cls;
   logic [3:0] kw_len;
   logic [63:0] aligned;
   logic [7:0] after_kw;
   chl_pkg::win_cnt_type rest;

   assign c  = win_ff[0];
   assign p1 = (cnt_ff > 4'd1) ? win_ff[1] : 8'd0;
   assign need_decide = busy_ff && (flush_ff ? (cnt_ff != 4'd0)
                                             : (cnt_ff == 4'(chl_pkg::WIN_DEPTH)));

   // First keyword of the table that matches at the head of the window.
   always_comb begin
      kw_hit  = 1'b0;
      kw_cls  = chl_pkg::CLS_KEYWORD;
      kw_len  = 4'd1;
      aligned = '0;
      after_kw = '0;
      kw_ok   = 1'b0;
      fits    = 1'b0;
      for (int i = 0; i < chl_pkg::KW_COUNT; i++) begin
         aligned  = chl_pkg::KW_TEXT[i] << (8 * (8 - int'(chl_pkg::KW_LEN[i])));
         fits     = flush_ff ? (chl_pkg::KW_LEN[i] <= cnt_ff) : (chl_pkg::KW_LEN[i] < cnt_ff);
         after_kw = (chl_pkg::KW_LEN[i] < cnt_ff) ? win_ff[chl_pkg::KW_LEN[i]] : 8'd0;
         kw_ok    = fits && chl_pkg::is_sep(after_kw);
         for (int j = 0; j < 8; j++) begin
            if (j < int'(chl_pkg::KW_LEN[i]) && win_ff[j] != aligned[63 - 8 * j -: 8]) begin
               kw_ok = 1'b0;
            end
         end
         if (kw_ok && !kw_hit) begin
            kw_hit = 1'b1;
            kw_len = chl_pkg::KW_LEN[i];
            kw_cls = chl_pkg::KW_IS_TYPE[i] ? chl_pkg::CLS_TYPE : chl_pkg::CLS_KEYWORD;
         end
      end
   end

   always_comb begin
      busy_in  = busy_ff;
      flush_in = flush_ff;
      left_in  = left_ff;
      ecls_in  = ecls_ff;
      elast_in = elast_ff;
      cnt_in   = cnt_ff;
      prev_in  = prev_ff;
      inbc_in  = inbc_ff;
      as_in    = as_ff;
      oq_in    = oq_ff;
      win_in   = win_ff;
      in_pop   = 1'b0;
      out_push = 1'b0;
      out_res.hl_class = ecls_ff;
      out_res.row_last = elast_ff && (left_ff == 4'd1);
      d_cls    = chl_pkg::CLS_NORMAL;
      d_len    = 4'd1;
      d_keep_prev = 1'b0;
      rest     = '0;

      if (left_ff != 4'd0) begin
         if (!out_full) begin
            out_push = 1'b1;
            left_in  = left_ff - 4'd1;
         end
      end else if (busy_ff) begin
         if (need_decide) begin
            priority if (!syntax_en) begin
               d_keep_prev = 1'b1;
            end else if (prev_ff == chl_pkg::CLS_COMMENT) begin
               d_cls = chl_pkg::CLS_COMMENT;
            end else if (oq_ff == 8'd0 && !inbc_ff && c == "/" && p1 == "/") begin
               d_cls = chl_pkg::CLS_COMMENT;
            end else if (oq_ff == 8'd0 && inbc_ff && c == "*" && p1 == "/") begin
               d_cls = chl_pkg::CLS_BLOCK;
               d_len = 4'd2;
               inbc_in = 1'b0;
               as_in = 1'b1;
            end else if (oq_ff == 8'd0 && inbc_ff) begin
               d_cls = chl_pkg::CLS_BLOCK;
            end else if (oq_ff == 8'd0 && c == "/" && p1 == "*") begin
               d_cls = chl_pkg::CLS_BLOCK;
               d_len = 4'd2;
               inbc_in = 1'b1;
            end else if (strings_en && oq_ff != 8'd0 && c == "\\" && cnt_ff >= 4'd2) begin
               d_cls = chl_pkg::CLS_STRING;
               d_len = 4'd2;
            end else if (strings_en && oq_ff != 8'd0) begin
               d_cls = chl_pkg::CLS_STRING;
               if (c == oq_ff) begin
                  oq_in = 8'd0;
               end
               as_in = 1'b1;
            end else if (strings_en && (c == "\"" || c == "'")) begin
               d_cls = chl_pkg::CLS_STRING;
               oq_in = c;
            end else if (numbers_en &&
                         ((c >= "0" && c <= "9" && (as_ff || prev_ff == chl_pkg::CLS_NUMBER))
                          || (c == "." && prev_ff == chl_pkg::CLS_NUMBER))) begin
               d_cls = chl_pkg::CLS_NUMBER;
               as_in = 1'b0;
            end else if (as_ff && kw_hit) begin
               d_cls = kw_cls;
               d_len = kw_len;
               as_in = 1'b0;
            end else begin
               as_in = chl_pkg::is_sep(c);
            end

            if (!d_keep_prev) begin
               prev_in = d_cls;
            end
            rest = cnt_ff - d_len;
            for (int j = 0; j < chl_pkg::WIN_DEPTH; j++) begin
               if (j + int'(d_len) < chl_pkg::WIN_DEPTH) begin
                  win_in[j] = win_ff[j + int'(d_len)];
               end
            end
            cnt_in   = rest;
            left_in  = d_len;
            ecls_in  = d_cls;
            elast_in = flush_ff && (rest == 4'd0);
            // The row is done: string, separator and class state start over.
            if (flush_ff && rest == 4'd0) begin
               oq_in   = 8'd0;
               as_in   = 1'b1;
               prev_in = chl_pkg::CLS_NORMAL;
            end
         end else begin
            busy_in = 1'b0;
         end
      end else if (!in_empty) begin
         in_pop   = 1'b1;
         busy_in  = 1'b1;
         flush_in = in_item.row_end;
         if (cnt_ff < 4'(chl_pkg::WIN_DEPTH)) begin
            win_in[cnt_ff] = in_item.text_char;
            cnt_in = cnt_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         flush_ff <= 1'b0;
         left_ff  <= '0;
         elast_ff <= 1'b0;
         cnt_ff   <= '0;
         prev_ff  <= chl_pkg::CLS_NORMAL;
         inbc_ff  <= 1'b0;
         as_ff    <= 1'b1;
         oq_ff    <= 8'd0;
      end else begin
         busy_ff  <= busy_in;
         flush_ff <= flush_in;
         left_ff  <= left_in;
         elast_ff <= elast_in;
         cnt_ff   <= cnt_in;
         prev_ff  <= prev_in;
         inbc_ff  <= inbc_in;
         as_ff    <= as_in;
         oq_ff    <= oq_in;
      end
   end

   always_ff @(posedge clock) begin
      ecls_ff <= ecls_in;
      win_ff  <= win_in;
   end
endmodule
`default_nettype wire

// ----- hdl/c_syntax_highlight_lexer.sv -----
// C syntax highlight lexer: takes one text byte per item and returns one highlight class
// per byte, in order, after a nine-byte lookahead window; a row end flushes the window.
// In the back end an item is taken and checked, then goes through its classification steps,
// each followed by its results, and the back end sets the throughput; items queue up
// in a four-entry input queue meanwhile, and a full result queue stalls the back end.
// Configuration writes are always ready and take effect on the next cycle.
`default_nettype none
module c_syntax_highlight_lexer (
   input  wire        clock,
   input  wire        reset,
   input  wire        push,
   output logic       full,
   input  wire [7:0]  req_text_char,
   input  wire        req_row_end,
   output logic       empty,
   input  wire        pop,
   output logic [2:0] rsp_hl_class,
   output logic       rsp_row_last,
   input  wire        csr_valid,
   output logic       csr_ready,
   input  wire [1:0]  csr_index,
   input  wire        csr_wdata
);
   logic syntax_en_ff, strings_en_ff, numbers_en_ff;
   chl_pkg::item_type   req_item, q_item;
   chl_pkg::result_type lex_res, rsp_res;
   logic q_empty, q_pop, o_full, o_push;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         syntax_en_ff  <= 1'b0;
         strings_en_ff <= 1'b1;
         numbers_en_ff <= 1'b1;
      end else if (csr_valid) begin
         unique case (csr_index)
            chl_pkg::CSR_SYNTAX_EN:  syntax_en_ff  <= csr_wdata;
            chl_pkg::CSR_STRINGS_EN: strings_en_ff <= csr_wdata;
            chl_pkg::CSR_NUMBERS_EN: numbers_en_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign req_item.text_char = req_text_char;
   assign req_item.row_end   = req_row_end;

   chl_front u_front (
      .clock(clock), .reset(reset), .push(push), .full(full), .push_item(req_item),
      .pop(q_pop), .empty(q_empty), .pop_item(q_item)
   );

   chl_lexer u_lexer (
      .clock(clock), .reset(reset), .syntax_en(syntax_en_ff), .strings_en(strings_en_ff),
      .numbers_en(numbers_en_ff), .in_empty(q_empty), .in_item(q_item), .in_pop(q_pop),
      .out_full(o_full), .out_push(o_push), .out_res(lex_res)
   );

   chl_outq u_outq (
      .clock(clock), .reset(reset), .push(o_push), .full(o_full), .push_res(lex_res),
      .pop(pop), .empty(empty), .pop_res(rsp_res)
   );

   assign rsp_hl_class = rsp_res.hl_class;
   assign rsp_row_last = rsp_res.row_last;
endmodule
`default_nettype wire

// ----- hdl/chl_checker.sv -----
// Port-level checks for the C syntax highlight lexer, bound to the top level.
// Depends on c_syntax_highlight_lexer only through its ports.
`default_nettype none
module chl_port_checks (
   input wire       clock,
   input wire       reset,
   input wire       full,
   input wire       empty,
   input wire       pop,
   input wire [2:0] rsp_hl_class,
   input wire       rsp_row_last
);
   a_reset_empty: assert property (@(posedge clock) reset |=> empty && !full)
      else $error("queues not empty after reset");
   a_class_range: assert property (@(posedge clock) disable iff (reset)
      !empty |-> rsp_hl_class <= 3'd6)
      else $error("highlight class out of range");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !empty && !pop |=> !empty)
      else $error("waiting result vanished");
   a_stable: assert property (@(posedge clock) disable iff (reset)
      !empty && !pop |=> $stable(rsp_hl_class) && $stable(rsp_row_last))
      else $error("waiting result changed");
endmodule

bind c_syntax_highlight_lexer chl_port_checks u_chl_checker (
   .clock(clock), .reset(reset), .full(full), .empty(empty), .pop(pop),
   .rsp_hl_class(rsp_hl_class), .rsp_row_last(rsp_row_last)
);
`default_nettype wire
